@@ hw/rtl/sip_pkg.sv @@
// Shared codes for the segment intersection point unit.
`timescale 1ns / 1ps
`default_nettype none
package sip_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        ST_CROSS    = 2'd0,
        ST_SHARED   = 2'd1,
        ST_PARALLEL = 2'd2,
        ST_NONE     = 2'd3
    } t_status;

endpackage
`default_nettype wire

@@ hw/rtl/sip_queue.sv @@
// Small register queue that parts the classifying front from the point back end.
`timescale 1ns / 1ps
`default_nettype none
module sip_queue #(
    parameter int W     = 263,
    parameter int DEPTH = 4
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_wr,
    input  wire logic [W-1:0] i_data,
    output logic              o_full,
    input  wire logic         i_rd,
    output logic              o_valid,
    output logic [W-1:0]      o_data
);
    localparam int PB = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CB = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PB-1:0] r_wr_ptr;
    logic [PB-1:0] r_rd_ptr;
    logic [CB-1:0] r_count;
    logic          wr_go;
    logic          rd_go;

    assign o_full  = (r_count == CB'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign wr_go   = i_wr && !o_full;
    assign rd_go   = i_rd && o_valid;

    // Store an entry on each write transfer
    always_ff @(posedge i_clk) begin
        if (wr_go) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_go) begin
                r_wr_ptr <= (r_wr_ptr == PB'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_go) begin
                r_rd_ptr <= (r_rd_ptr == PB'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_go && !rd_go) begin
                r_count <= r_count + 1'b1;
            end else if (rd_go && !wr_go) begin
                r_count <= r_count - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/sip_front.sv @@
// Front end: shared endpoint test, cross products and crossing classification.
`timescale 1ns / 1ps
`default_nettype none
module sip_front #(
    parameter  int COORD_BITS = 32,
    localparam int FW         = 8 * COORD_BITS + 7
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_push,
    output logic                              o_full,
    input  wire logic signed [COORD_BITS-1:0] i_a_start_lon,
    input  wire logic signed [COORD_BITS-2:0] i_a_start_lat,
    input  wire logic signed [COORD_BITS-1:0] i_a_end_lon,
    input  wire logic signed [COORD_BITS-2:0] i_a_end_lat,
    input  wire logic signed [COORD_BITS-1:0] i_b_start_lon,
    input  wire logic signed [COORD_BITS-2:0] i_b_start_lat,
    input  wire logic signed [COORD_BITS-1:0] i_b_end_lon,
    input  wire logic signed [COORD_BITS-2:0] i_b_end_lat,
    output logic                              o_valid,
    input  wire logic                         i_full,
    output logic [FW-1:0]                     o_data
);
    import sip_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int SW = 2 * C + 2;
    localparam int UD = 2 * C + 1;

    logic f_en;

    // Stage 0: captured item
    logic                r_v0;
    logic signed [C-1:0] r_ax0, r_ax1, r_bx0, r_bx1;
    logic signed [C-2:0] r_ay0, r_ay1, r_by0, r_by1;

    // Stage 1: differences and endpoint test
    logic                r_v1, r_sh1;
    logic signed [C-1:0] r_a0x1;
    logic signed [C-2:0] r_a0y1;
    logic signed [C:0]   r_dax1, r_dbx1, r_ox1;
    logic signed [C-1:0] r_day1, r_dby1, r_oy1;

    // Stage 2: products
    logic                r_v2, r_sh2;
    logic signed [C-1:0] r_a0x2;
    logic signed [C-2:0] r_a0y2;
    logic signed [C:0]   r_dax2;
    logic signed [C-1:0] r_day2;
    logic signed [2*C:0] r_pd1, r_pd2, r_pa1, r_pa2, r_pb1, r_pb2;

    // Stage 3: denominator and numerators
    logic                 r_v3, r_sh3;
    logic signed [C-1:0]  r_a0x3;
    logic signed [C-2:0]  r_a0y3;
    logic signed [C:0]    r_dax3;
    logic signed [C-1:0]  r_day3;
    logic signed [SW-1:0] r_den3, r_na3, r_nb3;

    // Stage 4: mirrored signs and magnitudes
    logic                 r_v4, r_sh4, r_dz4;
    logic signed [C-1:0]  r_a0x4;
    logic signed [C-2:0]  r_a0y4;
    logic                 r_xn4, r_yn4;
    logic [C:0]           r_xm4, r_ym4;
    logic signed [SW-1:0] r_den4, r_na4, r_nb4;

    // Stage 5: classified item
    logic                r_v5;
    t_status             r_st5;
    logic [UD-1:0]       r_den5, r_na5;
    logic signed [C-1:0] r_a0x5;
    logic signed [C-2:0] r_a0y5;
    logic                r_xn5, r_yn5;
    logic [C:0]          r_xm5, r_ym5;

    logic                 n_sh1;
    logic signed [SW-1:0] n_den4, n_na4, n_nb4;
    logic                 n_fail5;
    t_status              n_st5;

    // Stall the whole front only when the queue refuses the last stage
    assign f_en   = !(r_v5 && i_full);
    assign o_full = !f_en;

    assign o_valid = r_v5;
    assign o_data  = {r_st5, r_den5, r_na5, r_a0x5, r_a0y5, r_xn5, r_xm5, r_yn5, r_ym5};

    // Endpoint match
    always_comb begin
        n_sh1 = (r_ax0 == r_bx0 && r_ay0 == r_by0) || (r_ax0 == r_bx1 && r_ay0 == r_by1) ||
                (r_ax1 == r_bx0 && r_ay1 == r_by0) || (r_ax1 == r_bx1 && r_ay1 == r_by1);
    end

    // Mirror by the denominator sign
    always_comb begin
        if (r_den3[SW-1]) begin
            n_den4 = -r_den3;
            n_na4  = -r_na3;
            n_nb4  = -r_nb3;
        end else begin
            n_den4 = r_den3;
            n_na4  = r_na3;
            n_nb4  = r_nb3;
        end
    end

    // Classify in test order
    always_comb begin
        n_fail5 = r_na4[SW-1] || (r_na4 > r_den4) || r_nb4[SW-1] || (r_nb4 > r_den4);
        priority if (r_sh4) begin
            n_st5 = ST_SHARED;
        end else if (r_dz4) begin
            n_st5 = ST_PARALLEL;
        end else if (n_fail5) begin
            n_st5 = ST_NONE;
        end else begin
            n_st5 = ST_CROSS;
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (f_en) begin
            r_v0 <= i_push;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (f_en) begin
            r_ax0 <= i_a_start_lon;
            r_ay0 <= i_a_start_lat;
            r_ax1 <= i_a_end_lon;
            r_ay1 <= i_a_end_lat;
            r_bx0 <= i_b_start_lon;
            r_by0 <= i_b_start_lat;
            r_bx1 <= i_b_end_lon;
            r_by1 <= i_b_end_lat;

            r_sh1  <= n_sh1;
            r_a0x1 <= r_ax0;
            r_a0y1 <= r_ay0;
            r_dax1 <= $signed({r_ax1[C-1], r_ax1}) - $signed({r_ax0[C-1], r_ax0});
            r_day1 <= $signed({r_ay1[C-2], r_ay1}) - $signed({r_ay0[C-2], r_ay0});
            r_dbx1 <= $signed({r_bx1[C-1], r_bx1}) - $signed({r_bx0[C-1], r_bx0});
            r_dby1 <= $signed({r_by1[C-2], r_by1}) - $signed({r_by0[C-2], r_by0});
            r_ox1  <= $signed({r_ax0[C-1], r_ax0}) - $signed({r_bx0[C-1], r_bx0});
            r_oy1  <= $signed({r_ay0[C-2], r_ay0}) - $signed({r_by0[C-2], r_by0});

            r_sh2  <= r_sh1;
            r_a0x2 <= r_a0x1;
            r_a0y2 <= r_a0y1;
            r_dax2 <= r_dax1;
            r_day2 <= r_day1;
            r_pd1  <= r_dby1 * r_dax1;
            r_pd2  <= r_dbx1 * r_day1;
            r_pa1  <= r_dbx1 * r_oy1;
            r_pa2  <= r_dby1 * r_ox1;
            r_pb1  <= r_dax1 * r_oy1;
            r_pb2  <= r_day1 * r_ox1;

            r_sh3  <= r_sh2;
            r_a0x3 <= r_a0x2;
            r_a0y3 <= r_a0y2;
            r_dax3 <= r_dax2;
            r_day3 <= r_day2;
            r_den3 <= SW'(r_pd1) - SW'(r_pd2);
            r_na3  <= SW'(r_pa1) - SW'(r_pa2);
            r_nb3  <= SW'(r_pb1) - SW'(r_pb2);

            r_sh4  <= r_sh3;
            r_dz4  <= (r_den3 == '0);
            r_a0x4 <= r_a0x3;
            r_a0y4 <= r_a0y3;
            r_xn4  <= r_dax3[C];
            r_xm4  <= r_dax3[C] ? (C + 1)'(-r_dax3) : (C + 1)'(r_dax3);
            r_yn4  <= r_day3[C-1];
            r_ym4  <= r_day3[C-1] ? {1'b0, C'(-r_day3)} : {1'b0, C'(r_day3)};
            r_den4 <= n_den4;
            r_na4  <= n_na4;
            r_nb4  <= n_nb4;

            r_st5  <= n_st5;
            r_den5 <= r_den4[UD-1:0];
            r_na5  <= r_na4[UD-1:0];
            r_a0x5 <= r_a0x4;
            r_a0y5 <= r_a0y4;
            r_xn5  <= r_xn4;
            r_xm5  <= r_xm4;
            r_yn5  <= r_yn4;
            r_ym5  <= r_ym4;
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/sip_back.sv @@
// Back end: scaled offset products, pipelined division and rounding of the point.
`timescale 1ns / 1ps
`default_nettype none
module sip_back #(
    parameter  int COORD_BITS = 32,
    localparam int FW         = 8 * COORD_BITS + 7
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire logic [FW-1:0]         i_data,
    output logic                       o_take,
    output logic                       o_empty,
    input  wire logic                  i_pop,
    output logic [1:0]                 o_status,
    output logic [COORD_BITS-1:0]      o_cross_lon,
    output logic [COORD_BITS-2:0]      o_cross_lat
);
    import sip_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int UD = 2 * C + 1;
    localparam int QB = C + 1;
    localparam int PW = 3 * C + 2;
    localparam int BW = C + 3;

    typedef struct packed {
        logic                v;
        t_status             st;
        logic [UD-1:0]       den;
        logic signed [C-1:0] a0x;
        logic signed [C-2:0] a0y;
        logic                xn;
        logic                yn;
        logic [PW-1:0]       rx;
        logic [QB-1:0]       qx;
        logic [PW-1:0]       ry;
        logic [QB-1:0]       qy;
    } t_dv;

    // Unpacked queue entry
    logic [1:0]          q_st;
    logic [UD-1:0]       q_den, q_na;
    logic signed [C-1:0] q_a0x;
    logic signed [C-2:0] q_a0y;
    logic                q_xn, q_yn;
    logic [C:0]          q_xm, q_ym;

    logic b_en;
    logic r_out_valid;

    // Multiply stage
    logic                r_v0;
    t_status             r_st0;
    logic [UD-1:0]       r_den0;
    logic signed [C-1:0] r_a0x0;
    logic signed [C-2:0] r_a0y0;
    logic                r_xn0, r_yn0;
    logic [2*C+1:0]      r_plx0, r_ply0;
    logic [2*C:0]        r_phx0, r_phy0;

    // Division stages
    t_dv r_d [QB+1];
    t_dv n_d [QB+1];

    // Signed quotient and remainder stage
    logic                 r_v1;
    t_status              r_st1;
    logic [UD-1:0]        r_den1;
    logic signed [BW-1:0] r_bx1, r_by1;
    logic [UD-1:0]        r_rx1, r_ry1;

    logic signed [QB:0]   n_qx, n_qy;
    logic [UD-1:0]        n_rx, n_ry;
    logic                 n_upx, n_upy;
    logic signed [BW-1:0] n_resx, n_resy;

    assign {q_st, q_den, q_na, q_a0x, q_a0y, q_xn, q_xm, q_yn, q_ym} = i_data;

    // Stall only when a finished point waits and the output slot is not freed
    assign b_en    = !(r_v1 && r_out_valid && !i_pop);
    assign o_take  = b_en && i_valid;
    assign o_empty = !r_out_valid;

    // Split numerator times delta into two narrow partial products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (b_en) begin
            r_v0 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_en) begin
            r_st0  <= t_status'(q_st);
            r_den0 <= q_den;
            r_a0x0 <= q_a0x;
            r_a0y0 <= q_a0y;
            r_xn0  <= q_xn;
            r_yn0  <= q_yn;
            r_plx0 <= (2 * C + 2)'(q_na[C:0]) * (2 * C + 2)'(q_xm);
            r_phx0 <= (2 * C + 1)'(q_na[2*C:C+1]) * (2 * C + 1)'(q_xm);
            r_ply0 <= (2 * C + 2)'(q_na[C:0]) * (2 * C + 2)'(q_ym);
            r_phy0 <= (2 * C + 1)'(q_na[2*C:C+1]) * (2 * C + 1)'(q_ym);
        end
    end

    // Sum partial products into the dividend
    always_comb begin
        n_d[0]     = '0;
        n_d[0].v   = r_v0;
        n_d[0].st  = r_st0;
        n_d[0].den = r_den0;
        n_d[0].a0x = r_a0x0;
        n_d[0].a0y = r_a0y0;
        n_d[0].xn  = r_xn0;
        n_d[0].yn  = r_yn0;
        n_d[0].rx  = PW'(r_plx0) + (PW'(r_phx0) << (C + 1));
        n_d[0].ry  = PW'(r_ply0) + (PW'(r_phy0) << (C + 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d[0].v <= 1'b0;
        end else if (b_en) begin
            r_d[0] <= n_d[0];
        end
    end

    // One quotient bit per stage, most significant first
    for (genvar j = 0; j < QB; j++) begin : g_div
        logic [PW-1:0] dsh;

        assign dsh = PW'(r_d[j].den) << (QB - 1 - j);

        always_comb begin
            n_d[j+1] = r_d[j];
            if (r_d[j].rx >= dsh) begin
                n_d[j+1].rx            = r_d[j].rx - dsh;
                n_d[j+1].qx[QB-1-j]    = 1'b1;
            end
            if (r_d[j].ry >= dsh) begin
                n_d[j+1].ry            = r_d[j].ry - dsh;
                n_d[j+1].qy[QB-1-j]    = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d[j+1].v <= 1'b0;
            end else if (b_en) begin
                r_d[j+1] <= n_d[j+1];
            end
        end
    end

    // Floor quotient with sign of the delta, remainder kept non-negative
    always_comb begin
        if (!r_d[QB].xn) begin
            n_qx = $signed({1'b0, r_d[QB].qx});
            n_rx = r_d[QB].rx[UD-1:0];
        end else if (r_d[QB].rx == '0) begin
            n_qx = -$signed({1'b0, r_d[QB].qx});
            n_rx = '0;
        end else begin
            n_qx = -$signed({1'b0, r_d[QB].qx}) - (QB + 1)'(1);
            n_rx = r_d[QB].den - r_d[QB].rx[UD-1:0];
        end
        if (!r_d[QB].yn) begin
            n_qy = $signed({1'b0, r_d[QB].qy});
            n_ry = r_d[QB].ry[UD-1:0];
        end else if (r_d[QB].ry == '0) begin
            n_qy = -$signed({1'b0, r_d[QB].qy});
            n_ry = '0;
        end else begin
            n_qy = -$signed({1'b0, r_d[QB].qy}) - (QB + 1)'(1);
            n_ry = r_d[QB].den - r_d[QB].ry[UD-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (b_en) begin
            r_v1 <= r_d[QB].v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_en) begin
            r_st1  <= r_d[QB].st;
            r_den1 <= r_d[QB].den;
            r_bx1  <= BW'(r_d[QB].a0x) + BW'(n_qx);
            r_by1  <= BW'(r_d[QB].a0y) + BW'(n_qy);
            r_rx1  <= n_rx;
            r_ry1  <= n_ry;
        end
    end

    // Round to nearest, ties away from zero
    always_comb begin
        n_upx  = (r_rx1 != '0) && (({r_rx1, 1'b0} > {1'b0, r_den1}) ||
                 (({r_rx1, 1'b0} == {1'b0, r_den1}) && !r_bx1[BW-1]));
        n_upy  = (r_ry1 != '0) && (({r_ry1, 1'b0} > {1'b0, r_den1}) ||
                 (({r_ry1, 1'b0} == {1'b0, r_den1}) && !r_by1[BW-1]));
        n_resx = r_bx1 + $signed(BW'(n_upx));
        n_resy = r_by1 + $signed(BW'(n_upy));
    end

    // Output slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (b_en && r_v1) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_en && r_v1) begin
            o_status <= r_st1;
            if (r_st1 == ST_CROSS) begin
                o_cross_lon <= n_resx[C-1:0];
                o_cross_lat <= n_resy[C-2:0];
            end else begin
                o_cross_lon <= '0;
                o_cross_lat <= '0;
            end
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/segment_intersection_point_unit.sv @@
// Top level of the segment intersection point unit.
//
//   Channel   Handshake          Fields
//   input     push / full        a_start/a_end/b_start/b_end lon and lat
//   result    empty / pop        status, cross_lon, cross_lat
//
// One segment pair is taken per cycle while full is low, and one result
// leaves per cycle while pop is high and results are ready; the back end
// spends one pipeline stage per quotient bit.
// Reset clears all valid bits and the queue; no clearing pass is needed.
// The front stalls only when the four-entry queue is full, the back only
// when a result waits in the output slot and pop is low.
`timescale 1ns / 1ps
`default_nettype none
module segment_intersection_point_unit #(
    parameter int COORD_BITS = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         push,
    output logic                              full,
    input  wire logic signed [COORD_BITS-1:0] i_a_start_lon,
    input  wire logic signed [COORD_BITS-2:0] i_a_start_lat,
    input  wire logic signed [COORD_BITS-1:0] i_a_end_lon,
    input  wire logic signed [COORD_BITS-2:0] i_a_end_lat,
    input  wire logic signed [COORD_BITS-1:0] i_b_start_lon,
    input  wire logic signed [COORD_BITS-2:0] i_b_start_lat,
    input  wire logic signed [COORD_BITS-1:0] i_b_end_lon,
    input  wire logic signed [COORD_BITS-2:0] i_b_end_lat,
    output logic                              empty,
    input  wire logic                         pop,
    output logic [1:0]                        o_status,
    output logic signed [COORD_BITS-1:0]      o_cross_lon,
    output logic signed [COORD_BITS-2:0]      o_cross_lat
);
    import sip_pkg::*;

    localparam int FW = 8 * COORD_BITS + 7;

    logic          f_valid;
    logic          q_full;
    logic [FW-1:0] f_data;
    logic          q_valid;
    logic          q_take;
    logic [FW-1:0] q_data;
    logic [COORD_BITS-1:0] b_lon;
    logic [COORD_BITS-2:0] b_lat;

    // Classify
    sip_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_a_start_lon (i_a_start_lon),
        .i_a_start_lat (i_a_start_lat),
        .i_a_end_lon   (i_a_end_lon),
        .i_a_end_lat   (i_a_end_lat),
        .i_b_start_lon (i_b_start_lon),
        .i_b_start_lat (i_b_start_lat),
        .i_b_end_lon   (i_b_end_lon),
        .i_b_end_lat   (i_b_end_lat),
        .o_valid       (f_valid),
        .i_full        (q_full),
        .o_data        (f_data)
    );

    // Decouple front and back
    sip_queue #(.W(FW), .DEPTH(4)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (f_valid),
        .i_data  (f_data),
        .o_full  (q_full),
        .i_rd    (q_take),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    // Compute the crossing point
    sip_back #(.COORD_BITS(COORD_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_data      (q_data),
        .o_take      (q_take),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_status    (o_status),
        .o_cross_lon (b_lon),
        .o_cross_lat (b_lat)
    );

    assign o_cross_lon = $signed(b_lon);
    assign o_cross_lat = $signed(b_lat);
endmodule
`default_nettype wire

@@ tb/sip_checker.sv @@
// Checker for the segment intersection point unit: predicts each result and compares.
`timescale 1ns / 1ps
`default_nettype none
module sip_checker #(
    parameter int COORD_BITS = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_push,
    input  wire logic                         i_full,
    input  wire logic signed [COORD_BITS-1:0] i_a_start_lon,
    input  wire logic signed [COORD_BITS-2:0] i_a_start_lat,
    input  wire logic signed [COORD_BITS-1:0] i_a_end_lon,
    input  wire logic signed [COORD_BITS-2:0] i_a_end_lat,
    input  wire logic signed [COORD_BITS-1:0] i_b_start_lon,
    input  wire logic signed [COORD_BITS-2:0] i_b_start_lat,
    input  wire logic signed [COORD_BITS-1:0] i_b_end_lon,
    input  wire logic signed [COORD_BITS-2:0] i_b_end_lat,
    input  wire logic                         i_empty,
    input  wire logic                         i_pop,
    input  wire logic [1:0]                   i_status,
    input  wire logic signed [COORD_BITS-1:0] i_cross_lon,
    input  wire logic signed [COORD_BITS-2:0] i_cross_lat,
    output int                                o_fail_count,
    output int                                o_pending
);
    import sip_pkg::*;

    typedef struct packed {
        t_status                      status;
        logic signed [COORD_BITS-1:0] lon;
        logic signed [COORD_BITS-2:0] lat;
    } t_crossing;

    t_crossing crossing_q[$];

    // Divide rounding to nearest, ties away from zero; d is positive
    function automatic logic signed [127:0] round_quot(logic signed [127:0] n,
                                                       logic signed [127:0] d);
        logic signed [127:0] mag;
        logic signed [127:0] q;
        logic signed [127:0] r;
        mag = (n < 0) ? -n : n;
        q   = mag / d;
        r   = mag % d;
        if (r >= d - r) q = q + 1;
        return (n < 0) ? -q : q;
    endfunction

    function automatic t_crossing predict_crossing(
        logic signed [127:0] ax0, logic signed [127:0] ay0,
        logic signed [127:0] ax1, logic signed [127:0] ay1,
        logic signed [127:0] bx0, logic signed [127:0] by0,
        logic signed [127:0] bx1, logic signed [127:0] by1);
        t_crossing           res;
        logic signed [127:0] dax, day, dbx, dby, ox, oy, den, na, nb, px, py;
        res = '0;
        res.status = ST_CROSS;
        if ((ax0 == bx0 && ay0 == by0) || (ax0 == bx1 && ay0 == by1) ||
            (ax1 == bx0 && ay1 == by0) || (ax1 == bx1 && ay1 == by1)) begin
            res.status = ST_SHARED;
            return res;
        end
        dax = ax1 - ax0;
        day = ay1 - ay0;
        dbx = bx1 - bx0;
        dby = by1 - by0;
        ox  = ax0 - bx0;
        oy  = ay0 - by0;
        den = dby * dax - dbx * day;
        if (den == 0) begin
            res.status = ST_PARALLEL;
            return res;
        end
        na = dbx * oy - dby * ox;
        nb = dax * oy - day * ox;
        if (den < 0) begin
            den = -den;
            na  = -na;
            nb  = -nb;
        end
        if (na < 0 || na > den || nb < 0 || nb > den) begin
            res.status = ST_NONE;
            return res;
        end
        px = round_quot(ax0 * den + na * dax, den);
        py = round_quot(ay0 * den + na * day, den);
        res.lon = px[COORD_BITS-1:0];
        res.lat = py[COORD_BITS-2:0];
        return res;
    endfunction

    // Predict on each input transfer, compare on each result transfer
    always @(posedge i_clk) begin
        t_crossing want;
        int        bad;
        bad = 0;
        if (i_rst_n && i_push && !i_full) begin
            crossing_q.push_back(predict_crossing(
                i_a_start_lon, i_a_start_lat, i_a_end_lon, i_a_end_lat,
                i_b_start_lon, i_b_start_lat, i_b_end_lon, i_b_end_lat));
        end
        if (i_rst_n && i_pop && !i_empty) begin
            if (crossing_q.size() == 0) begin
                $error("result transfer with nothing expected");
                bad = bad + 1;
            end else begin
                want = crossing_q.pop_front();
                if (i_status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, i_status);
                    bad = bad + 1;
                end
                if (i_cross_lon !== want.lon) begin
                    $error("cross_lon expected %0d actual %0d", want.lon, i_cross_lon);
                    bad = bad + 1;
                end
                if (i_cross_lat !== want.lat) begin
                    $error("cross_lat expected %0d actual %0d", want.lat, i_cross_lat);
                    bad = bad + 1;
                end
            end
        end
        if (bad != 0) o_fail_count <= o_fail_count + bad;
        o_pending <= crossing_q.size();
    end

endmodule
`default_nettype wire

@@ tb/tb_segment_intersection_point_unit.sv @@
// Testbench top for the segment intersection point unit: stimulus and verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb_segment_intersection_point_unit;
    import sip_pkg::*;

    localparam int CB = 32;
    localparam int DRAIN_CYCLES = 3 * (CB + 16);

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 pop = 1'b0;
    logic                 full, empty;
    logic signed [CB-1:0] a0x = '0, a1x = '0, b0x = '0, b1x = '0;
    logic signed [CB-2:0] a0y = '0, a1y = '0, b0y = '0, b1y = '0;
    logic [1:0]           o_status;
    logic signed [CB-1:0] o_cross_lon;
    logic signed [CB-2:0] o_cross_lat;
    int                   fail_count, pending;
    int                   send_idle = 0;
    int                   recv_stall = 0;
    bit                   hold_off = 1'b0;

    always #2 i_clk = ~i_clk;

    segment_intersection_point_unit #(.COORD_BITS(CB)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_a_start_lon(a0x), .i_a_start_lat(a0y), .i_a_end_lon(a1x), .i_a_end_lat(a1y),
        .i_b_start_lon(b0x), .i_b_start_lat(b0y), .i_b_end_lon(b1x), .i_b_end_lat(b1y),
        .empty(empty), .pop(pop), .o_status(o_status),
        .o_cross_lon(o_cross_lon), .o_cross_lat(o_cross_lat)
    );

    sip_checker #(.COORD_BITS(CB)) checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_full(full),
        .i_a_start_lon(a0x), .i_a_start_lat(a0y), .i_a_end_lon(a1x), .i_a_end_lat(a1y),
        .i_b_start_lon(b0x), .i_b_start_lat(b0y), .i_b_end_lon(b1x), .i_b_end_lat(b1y),
        .i_empty(empty), .i_pop(pop), .i_status(o_status),
        .i_cross_lon(o_cross_lon), .i_cross_lat(o_cross_lat),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Random in-range coordinate, sometimes from a tiny grid to force hits
    function automatic logic signed [CB-1:0] rand_lon(bit tiny);
        if (tiny) return $signed($urandom_range(0, 8)) - 4;
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return (CB == 32) ? 32'sd1800000000 : $urandom;
            2:       return (CB == 32) ? -32'sd1800000000 : $urandom;
            default: return $signed($urandom_range(0, 2000000)) - 1000000;
        endcase
    endfunction

    function automatic logic signed [CB-2:0] rand_lat(bit tiny);
        if (tiny) return (CB - 1)'($signed($urandom_range(0, 8)) - 4);
        case ($urandom_range(0, 9))
            0:       return (CB - 1)'($urandom);
            1:       return (CB == 32) ? 31'sd900000000 : (CB - 1)'($urandom);
            2:       return (CB == 32) ? -31'sd900000000 : (CB - 1)'($urandom);
            default: return (CB - 1)'($signed($urandom_range(0, 2000000)) - 1000000);
        endcase
    endfunction

    // Offer one pair and hold it until the transfer
    task automatic send_pair(logic signed [CB-1:0] ax0, logic signed [CB-2:0] ay0,
                             logic signed [CB-1:0] ax1, logic signed [CB-2:0] ay1,
                             logic signed [CB-1:0] bx0, logic signed [CB-2:0] by0,
                             logic signed [CB-1:0] bx1, logic signed [CB-2:0] by1);
        while (send_idle > 0 && $urandom_range(0, 99) < send_idle) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        a0x <= ax0; a0y <= ay0; a1x <= ax1; a1y <= ay1;
        b0x <= bx0; b0y <= by0; b1x <= bx1; b1y <= by1;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    task automatic send_random(int count);
        logic signed [CB-1:0] x0, x1, x2, x3;
        logic signed [CB-2:0] y0, y1, y2, y3;
        bit                   tiny;
        for (int n = 0; n < count; n++) begin
            tiny = ($urandom_range(0, 3) == 0);
            x0 = rand_lon(tiny); x1 = rand_lon(tiny); x2 = rand_lon(tiny); x3 = rand_lon(tiny);
            y0 = rand_lat(tiny); y1 = rand_lat(tiny); y2 = rand_lat(tiny); y3 = rand_lat(tiny);
            // In three of ten draws, crossing diagonals: B spans the box of A the other way
            case ($urandom_range(0, 9))
                0:       begin x2 = x0; y2 = y0; end
                1:       begin x1 = x0; y1 = y0; end
                2:       begin x2 = x0 + ((x1 - x0) <<< 1); y2 = y0 + ((y1 - y0) <<< 1);
                               x3 = x0 - (x1 - x0); y3 = y0 - (y1 - y0); end
                3, 4, 5: begin x2 = x0; y2 = y1; x3 = x1; y3 = y0; end
                default: ;
            endcase
            send_pair(x0, y0, x1, y1, x2, y2, x3, y3);
        end
        push <= 1'b0;
    endtask

    task automatic wait_drained;
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Receiver: random stalls, or a long counted hold-off
    always @(posedge i_clk) begin
        if (hold_off) pop <= 1'b0;
        else pop <= ($urandom_range(0, 99) >= recv_stall);
    end

    initial begin
        #2000000;
        $display("[segment_intersection_point_unit] ERROR");
        $finish;
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, shared endpoints, parallel, degenerate, miss, cross
        send_pair(0, 0, 10, 10, 0, 10, 10, 0);
        send_pair(0, 0, 10, 10, 10, 10, 20, 0);
        send_pair(0, 0, 10, 10, 5, 0, 0, 0);
        send_pair(0, 0, 10, 0, 0, 5, 10, 5);
        send_pair(0, 0, 10, 10, 20, 20, 30, 30);
        send_pair(3, 3, 3, 3, 0, 5, 5, 0);
        send_pair(0, 0, 10, 10, 20, 0, 30, -10);
        send_pair(0, 0, 3, 2, 0, 1, 3, 0);
        send_pair(-3, 0, 0, 1, -3, 1, 0, 0);
        send_pair(0, 0, 10, 10, 5, 5, 0, 10);
        send_pair(-32'sd1800000000, -31'sd900000000, 32'sd1800000000, 31'sd900000000,
                  -32'sd1800000000, 31'sd900000000, 32'sd1800000000, -31'sd900000000);
        send_pair(32'sh7fffffff, 31'sh3fffffff, 32'sh80000000, 31'sh40000000,
                  32'sh80000000, 31'sh3fffffff, 32'sh7fffffff, 31'sh40000000);
        send_pair(-1, -1, 32'sh7fffffff, 31'sh3fffffff, 0, 31'sh3fffffff, 32'sh7fffffff, 0);
        send_pair(32'sh80000000, 0, 0, 31'sh40000000, 32'sh80000000, 31'sh40000000, 0, 0);
        wait_drained();

        // Phases: none, sender idle, receiver stall, both
        send_idle = 0;  recv_stall = 0;  send_random(300);
        send_idle = 60; recv_stall = 0;  send_random(250);
        wait_drained();
        send_idle = 0;  recv_stall = 60; send_random(250);
        send_idle = 23; recv_stall = 23; send_random(250);

        // Long receiver hold-off while the sender keeps pushing
        send_idle = 0;  recv_stall = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (150) @(posedge i_clk);
                hold_off = 1'b0;
            end
            send_random(200);
        join

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("[segment_intersection_point_unit] OK");
        end else begin
            $display("[segment_intersection_point_unit] ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire

@@ segment_intersection_point_unit.f @@
hw/rtl/sip_pkg.sv
hw/rtl/sip_queue.sv
hw/rtl/sip_front.sv
hw/rtl/sip_back.sv
hw/rtl/segment_intersection_point_unit.sv
tb/sip_checker.sv
tb/tb_segment_intersection_point_unit.sv
